// ===== rtl/pat_pkg.sv =====
// Shared types, action codes and ordering functions for the alert table.
// Used by pat_slot_mem and priority_alert_table_with_expiry_unit.
`default_nettype none
package pat_pkg;

  typedef enum logic [2:0] {
    ACT_PUSH     = 3'd0,
    ACT_TICK     = 3'd1,
    ACT_DIS_ID   = 3'd2,
    ACT_DIS_CAT  = 3'd3,
    ACT_CLEAR    = 3'd4,
    ACT_LIST_ALL = 3'd5,
    ACT_LIST_CAT = 3'd6,
    ACT_RSVD     = 3'd7
  } action_t;

  localparam int MaxResults = 16;
  localparam logic [23:0] AgeMax = 24'hFFFFFF;
  localparam logic [4:0] MaxAlertsReset = 5'd16;

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  cat;
    logic [7:0]  prio;
    logic [23:0] time_left;
    logic [23:0] age;
    logic [15:0] tag;
  } slot_t;

  // True if a goes out before b on eviction: lower priority, older, lower id.
  function automatic logic pat_worse(input slot_t a, input slot_t b);
    return {~a.prio, a.age, ~a.id} > {~b.prio, b.age, ~b.id};
  endfunction

  // True if a is listed before b: higher priority, younger, lower id.
  function automatic logic pat_better(input slot_t a, input slot_t b);
    return {a.prio, ~a.age, ~a.id} > {b.prio, ~b.age, ~b.id};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pat_slot_mem.sv =====
// Slot payload memory: one write port and one registered read port.
// Depends on pat_pkg for the slot record type.
`default_nettype none
module pat_slot_mem #(
  parameter int DEPTH = 16
) (
  input  wire                       clk,
  input  wire                       wr_en,
  input  wire [$clog2(DEPTH)-1:0]   wr_addr,
  input  pat_pkg::slot_t            wr_data,
  input  wire [$clog2(DEPTH)-1:0]   rd_addr,
  output pat_pkg::slot_t            rd_data
);
  import pat_pkg::*;

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/priority_alert_table_with_expiry_unit.sv =====
// Top level of the priority alert table: sequencer, valid bits and counters.
// Depends on pat_pkg and pat_slot_mem.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   in       | in_valid/in_stall  | action, category, priority_req, duration_ms,
//            |                    | delta_ms, target_id, message_tag
//   out      | out_valid/out_stall| new_id .. entry_message_tag, last
//   cfg      | cfg_we             | cfg_wdata (max_alerts)
//
// Tick, dismiss, push and list walk the slot memory one entry a cycle through its single
// read port. Clear and unused codes go straight to the result. A push scans the table,
// evicting one entry (or dropping the new one) per pass while over the cap, then places
// it; a list counts eligible entries, then scans once per item (an empty list only counts).
// Reset is synchronous and empties the table at once.
// A stalled output holds the sequencer before it writes its next result.
`default_nettype none
module priority_alert_table_with_expiry_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  action,
  input  wire  [7:0]  category,
  input  wire  [7:0]  priority_req,
  input  wire  [23:0] duration_ms,
  input  wire  [15:0] delta_ms,
  input  wire  [31:0] target_id,
  input  wire  [15:0] message_tag,
  input  wire         cfg_we,
  input  wire  [4:0]  cfg_wdata,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [31:0] new_id,
  output logic        found,
  output logic [4:0]  removed_count,
  output logic [4:0]  active_count,
  output logic        entry_valid,
  output logic [31:0] entry_id,
  output logic [7:0]  entry_category,
  output logic [7:0]  entry_priority,
  output logic [23:0] entry_time_left,
  output logic [23:0] entry_age,
  output logic [15:0] entry_message_tag,
  output logic        last
);
  import pat_pkg::*;

  localparam int N  = TABLE_ENTRIES;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(N + 1);
  localparam logic [AW-1:0] LastIdx = AW'(N - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PSCAN, S_PEVICT, S_PPLACE, S_TSCAN, S_DSCAN,
    S_LCOUNT, S_LSCAN, S_LOUT, S_RESULT
  } state_t;

  state_t        state;
  action_t       op;
  logic [7:0]    op_cat;
  logic [7:0]    op_pri;
  logic [23:0]   op_dur;
  logic [15:0]   op_delta;
  logic [31:0]   op_target;
  logic [15:0]   op_tag;
  logic [4:0]    max_alerts;
  logic [31:0]   next_alert_id;

  logic [N-1:0]  used;
  logic [N-1:0]  live;
  logic [N-1:0]  taken;
  logic [CW-1:0] held_cnt;
  logic [CW-1:0] act_cnt;

  logic [AW-1:0] sc_idx;
  logic          sc_run;
  logic [AW-1:0] p_idx;
  logic          p_vld;

  slot_t         sel_rec;
  logic [AW-1:0] sel_idx;
  logic          sel_vld;
  logic [AW-1:0] ff_idx;
  logic          ff_vld;
  logic          new_pend;

  logic [31:0]   res_new_id;
  logic          res_found;
  logic [4:0]    res_removed;
  logic [CW-1:0] elig_cnt;
  logic [4:0]    lst_total;
  logic [4:0]    lst_n;

  slot_t         rd_rec;
  slot_t         new_rec;
  slot_t         tick_rec;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  slot_t         mem_wdata;

  logic          out_free;
  logic          used_p;
  logic          live_p;
  logic          elig_p;
  logic [24:0]   age_sum;
  logic [7:0]    cap;
  logic [7:0]    total;
  logic [4:0]    act_sat;
  logic [7:0]    act_wide;
  logic [4:0]    elig_min;
  logic [7:0]    elig_wide;

  pat_slot_mem #(.DEPTH(N)) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (sc_idx),
    .rd_data (rd_rec)
  );

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign used_p   = used[p_idx];
  assign live_p   = live[p_idx];
  assign elig_p   = used_p && live_p && !taken[p_idx] &&
                    (op != ACT_LIST_CAT || rd_rec.cat == op_cat);

  always_comb begin
    new_rec           = '0;
    new_rec.id        = res_new_id;
    new_rec.cat       = op_cat;
    new_rec.prio      = op_pri;
    new_rec.time_left = op_dur;
    new_rec.tag       = op_tag;

    age_sum            = {1'b0, rd_rec.age} + 25'(op_delta);
    tick_rec           = rd_rec;
    tick_rec.age       = age_sum[24] ? AgeMax : age_sum[23:0];
    tick_rec.time_left = (rd_rec.time_left > 24'(op_delta)) ?
                         rd_rec.time_left - 24'(op_delta) : 24'd0;

    cap   = (8'(max_alerts) > 8'(N)) ? 8'(N) : 8'(max_alerts);
    total = 8'(held_cnt) + 8'(new_pend);

    act_wide  = 8'(act_cnt);
    act_sat   = (act_wide > 8'd31) ? 5'd31 : act_wide[4:0];
    elig_wide = 8'(elig_cnt);
    elig_min  = (elig_wide > 8'(MaxResults)) ? 5'(MaxResults) : elig_wide[4:0];

    mem_we    = 1'b0;
    mem_waddr = p_idx;
    mem_wdata = tick_rec;
    if (state == S_TSCAN && p_vld && used_p) begin
      mem_we = 1'b1;
    end else if (state == S_PPLACE && new_pend) begin
      mem_we    = 1'b1;
      mem_waddr = ff_idx;
      mem_wdata = new_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      max_alerts    <= MaxAlertsReset;
      next_alert_id <= '0;
      used          <= '0;
      live          <= '0;
      taken         <= '0;
      held_cnt      <= '0;
      act_cnt       <= '0;
      sc_run        <= 1'b0;
      p_vld         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_alerts <= cfg_wdata;
      end

      // Read sequencing: issue one address a cycle; its data comes back in the cycle after.
      p_vld <= sc_run;
      p_idx <= sc_idx;
      if (sc_run) begin
        if (sc_idx == LastIdx) begin
          sc_run <= 1'b0;
        end else begin
          sc_idx <= sc_idx + 1'b1;
        end
      end

      // The result states load a new transaction when the old one leaves.
      if (out_valid && !out_stall && state != S_LOUT && state != S_RESULT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op          <= action_t'(action);
            op_cat      <= category;
            op_pri      <= priority_req;
            op_dur      <= duration_ms;
            op_delta    <= delta_ms;
            op_target   <= target_id;
            op_tag      <= message_tag;
            res_new_id  <= '0;
            res_found   <= 1'b0;
            res_removed <= '0;
            sel_vld     <= 1'b0;
            ff_vld      <= 1'b0;
            taken       <= '0;
            elig_cnt    <= '0;
            lst_n       <= '0;
            sc_idx      <= '0;
            unique case (action_t'(action))
              ACT_PUSH: begin
                res_new_id    <= next_alert_id;
                next_alert_id <= next_alert_id + 32'd1;
                new_pend      <= 1'b1;
                sc_run        <= 1'b1;
                state         <= S_PSCAN;
              end
              ACT_TICK: begin
                sc_run <= 1'b1;
                state  <= S_TSCAN;
              end
              ACT_DIS_ID, ACT_DIS_CAT: begin
                sc_run <= 1'b1;
                state  <= S_DSCAN;
              end
              ACT_CLEAR: begin
                used     <= '0;
                live     <= '0;
                held_cnt <= '0;
                act_cnt  <= '0;
                state    <= S_RESULT;
              end
              ACT_LIST_ALL, ACT_LIST_CAT: begin
                sc_run <= 1'b1;
                state  <= S_LCOUNT;
              end
              default: begin
                state <= S_RESULT;
              end
            endcase
          end
        end

        S_PSCAN: begin
          if (p_vld) begin
            if (used_p) begin
              if (!sel_vld || pat_worse(rd_rec, sel_rec)) begin
                sel_rec <= rd_rec;
                sel_idx <= p_idx;
                sel_vld <= 1'b1;
              end
            end else if (!ff_vld) begin
              ff_idx <= p_idx;
              ff_vld <= 1'b1;
            end
            if (p_idx == LastIdx) begin
              state <= S_PEVICT;
            end
          end
        end

        S_PEVICT: begin
          if (total > cap) begin
            if (new_pend && (!sel_vld || pat_worse(new_rec, sel_rec))) begin
              new_pend <= 1'b0;
            end else begin
              used[sel_idx] <= 1'b0;
              live[sel_idx] <= 1'b0;
              held_cnt      <= held_cnt - 1'b1;
              if (live[sel_idx]) begin
                act_cnt <= act_cnt - 1'b1;
              end
              if (!ff_vld || sel_idx < ff_idx) begin
                ff_idx <= sel_idx;
                ff_vld <= 1'b1;
              end
            end
            if (total - 8'd1 > cap) begin
              sel_vld <= 1'b0;
              ff_vld  <= 1'b0;
              sc_idx  <= '0;
              sc_run  <= 1'b1;
              state   <= S_PSCAN;
            end else begin
              state <= S_PPLACE;
            end
          end else begin
            state <= S_PPLACE;
          end
        end

        S_PPLACE: begin
          // A free slot always exists here when the new alert survived.
          if (new_pend) begin
            used[ff_idx] <= 1'b1;
            live[ff_idx] <= (op_dur != 24'd0);
            held_cnt     <= held_cnt + 1'b1;
            if (op_dur != 24'd0) begin
              act_cnt <= act_cnt + 1'b1;
            end
          end
          state <= S_RESULT;
        end

        S_TSCAN: begin
          if (p_vld) begin
            if (used_p) begin
              live[p_idx] <= (tick_rec.time_left != 24'd0);
              if (tick_rec.time_left == 24'd0) begin
                used[p_idx] <= 1'b0;
                held_cnt    <= held_cnt - 1'b1;
                if (live_p) begin
                  act_cnt <= act_cnt - 1'b1;
                end
              end
            end
            if (p_idx == LastIdx) begin
              state <= S_RESULT;
            end
          end
        end

        S_DSCAN: begin
          if (p_vld) begin
            if (used_p && ((op == ACT_DIS_ID && rd_rec.id == op_target && !res_found) ||
                           (op == ACT_DIS_CAT && rd_rec.cat == op_cat))) begin
              used[p_idx] <= 1'b0;
              live[p_idx] <= 1'b0;
              held_cnt    <= held_cnt - 1'b1;
              if (live_p) begin
                act_cnt <= act_cnt - 1'b1;
              end
              if (op == ACT_DIS_ID) begin
                res_found <= 1'b1;
              end else if (res_removed != 5'd31) begin
                res_removed <= res_removed + 5'd1;
              end
            end
            if (p_idx == LastIdx) begin
              state <= S_RESULT;
            end
          end
        end

        S_LCOUNT: begin
          if (p_vld) begin
            if (elig_p) begin
              elig_cnt <= elig_cnt + 1'b1;
            end
            if (p_idx == LastIdx) begin
              if (elig_cnt == '0 && !elig_p) begin
                state <= S_RESULT;
              end else begin
                sc_idx <= '0;
                sc_run <= 1'b1;
                state  <= S_LSCAN;
              end
            end
          end
        end

        S_LSCAN: begin
          lst_total <= elig_min;
          if (p_vld) begin
            if (elig_p && (!sel_vld || pat_better(rd_rec, sel_rec))) begin
              sel_rec <= rd_rec;
              sel_idx <= p_idx;
              sel_vld <= 1'b1;
            end
            if (p_idx == LastIdx) begin
              state <= S_LOUT;
            end
          end
        end

        S_LOUT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            new_id            <= '0;
            found             <= 1'b0;
            removed_count     <= '0;
            active_count      <= act_sat;
            entry_valid       <= 1'b1;
            entry_id          <= sel_rec.id;
            entry_category    <= sel_rec.cat;
            entry_priority    <= sel_rec.prio;
            entry_time_left   <= sel_rec.time_left;
            entry_age         <= sel_rec.age;
            entry_message_tag <= sel_rec.tag;
            last              <= (lst_n + 5'd1 == lst_total);
            taken[sel_idx]    <= 1'b1;
            sel_vld           <= 1'b0;
            lst_n             <= lst_n + 5'd1;
            if (lst_n + 5'd1 == lst_total) begin
              state <= S_IDLE;
            end else begin
              sc_idx <= '0;
              sc_run <= 1'b1;
              state  <= S_LSCAN;
            end
          end
        end

        S_RESULT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            new_id            <= res_new_id;
            found             <= res_found;
            removed_count     <= res_removed;
            active_count      <= act_sat;
            entry_valid       <= 1'b0;
            entry_id          <= '0;
            entry_category    <= '0;
            entry_priority    <= '0;
            entry_time_left   <= '0;
            entry_age         <= '0;
            entry_message_tag <= '0;
            last              <= 1'b1;
            state             <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
